// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/tpsg_pkg.sv =====
// Types, constants and the sine table function of the turtle path segment generator.
package tpsg_pkg;

   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int SINE_PROD_W = 15 + SINE_IDX_W;

   localparam logic [7:0] SYM_A     = 8'h41;
   localparam logic [7:0] SYM_B     = 8'h42;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;

   localparam logic [7:0] CSR_STEP_LENGTH = 8'd0;
   localparam logic [7:0] CSR_TURN_ANGLE  = 8'd1;
   localparam logic [7:0] CSR_START_X     = 8'd2;
   localparam logic [7:0] CSR_START_Y     = 8'd3;

   localparam logic [15:0]        STEP_LENGTH_RESET = 16'd2560;
   localparam logic [15:0]        TURN_ANGLE_RESET  = 16'd10923;
   localparam logic signed [23:0] START_X_RESET     = 24'sd166400;
   localparam logic signed [23:0] START_Y_RESET     = 24'sd115200;
   localparam logic [15:0]        HEADING_RESET     = 16'd16384;
   localparam logic [15:0]        QUARTER_TURN      = 16'd16384;

   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] POS_MIN = 24'sh800000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [15:0]     SINE_ONE    = 16'd32768;

   typedef struct packed {
      logic [7:0] symbol;
      logic       path_begin;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] from_x;
      logic signed [23:0] from_y;
      logic signed [23:0] to_x;
      logic signed [23:0] to_y;
   } rsp_payload_type;

   // Quarter-wave sine entry in unsigned Q15. Only evaluated with constant
   // arguments while the table is elaborated.
   function automatic logic [15:0] sine_entry(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned q;
      longint          sum;
      if (k >= SINE_TABLE_ENTRIES) begin
         return SINE_ONE;
      end
      x = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      q = (longint'(unsigned'(sum)) + 64'd16384) >> 15;
      if (q > 64'd32768) begin
         q = 64'd32768;
      end
      return q[15:0];
   endfunction

endpackage

// ===== rtl/tpsg_sine_rom.sv =====
// Quarter-wave sine table with two registered read ports.
module tpsg_sine_rom
   import tpsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [SINE_IDX_W-1:0] rd_addr_a,
   input  logic [SINE_IDX_W-1:0] rd_addr_b,
   output logic [15:0]           rd_data_a,
   output logic [15:0]           rd_data_b
);

   logic [15:0] sine_rom [0:SINE_TABLE_ENTRIES];
   logic [15:0] rd_data_a_ff;
   logic [15:0] rd_data_b_ff;

   for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_entry
      assign sine_rom[k] = sine_entry(k);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= sine_rom[rd_addr_a];
         rd_data_b_ff <= sine_rom[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/turtle_path_segment_generator.sv =====
// Turtle path segment generator: heading tracking, table lookup, scaled step and pen update.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | symbol, path_begin
//   rsp     | out       | rsp_valid/rsp_stall | from_x, from_y, to_x, to_y
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One symbol is taken per cycle while no stalled result waits; a draw symbol's segment
// reaches rsp through the registered sine table read, the step multiply stage and the
// saturating pen adder that feeds the result register.
// Reset is synchronous; there is no clearing pass.
// A stalled result freezes the whole pipeline and raises req_stall in the same cycle.
module turtle_path_segment_generator
   import tpsg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [23:0]     csr_wdata
);

   typedef struct packed {
      logic valid;
      logic draw;
      logic path_begin;
   } stage_ctrl_type;

   typedef struct packed {
      logic [SINE_IDX_W-1:0] idx;
      logic                  neg;
   } sine_addr_type;

   logic [15:0]        step_length_ff;
   logic [15:0]        turn_angle_ff;
   logic signed [23:0] start_x_ff;
   logic signed [23:0] start_y_ff;

   logic [15:0]        heading_ff;
   logic [15:0]        heading_in;
   logic [15:0]        heading_eff;
   logic signed [23:0] pen_x_ff;
   logic signed [23:0] pen_y_ff;

   logic pipe_en;
   logic accept;
   logic is_draw;

   stage_ctrl_type s1_ff;
   stage_ctrl_type s2_ff;
   logic           s1_neg_x_ff;
   logic           s1_neg_y_ff;
   logic           s2_neg_x_ff;
   logic           s2_neg_y_ff;
   logic [15:0]    s2_dmag_x_ff;
   logic [15:0]    s2_dmag_y_ff;

   sine_addr_type  cos_addr;
   sine_addr_type  sin_addr;
   logic [15:0]    cos_mag;
   logic [15:0]    sin_mag;
   logic [15:0]    dmag_x_in;
   logic [15:0]    dmag_y_in;

   logic signed [23:0] base_x;
   logic signed [23:0] base_y;
   logic signed [23:0] next_x;
   logic signed [23:0] next_y;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // Maps a binary angle to a quarter-wave table index and a sign.
   function automatic sine_addr_type sine_addr(input logic [15:0] angle);
      logic [14:0]            phase;
      logic [SINE_PROD_W-1:0] prod;
      sine_addr_type          res;
      phase = {1'b0, angle[13:0]};
      if (angle[14]) begin
         phase = 15'd16384 - phase;
      end
      prod = SINE_PROD_W'(phase) * SINE_PROD_W'(SINE_TABLE_ENTRIES);
      res.idx = prod[14 +: SINE_IDX_W];
      res.neg = angle[15];
      return res;
   endfunction

   // Rounded step times table magnitude, back to pixel units.
   function automatic logic [15:0] scale_step(input logic [15:0] step, input logic [15:0] mag);
      logic [31:0] prod;
      logic [32:0] rnd;
      prod = step * mag;
      rnd = {1'b0, prod} + 33'd16384;
      return rnd[30:15];
   endfunction

   function automatic logic signed [23:0] sat_add(input logic signed [23:0] base,
                                                   input logic [15:0] mag,
                                                   input logic neg);
      logic [24:0] delta;
      logic [24:0] sum;
      delta = {9'b0, mag};
      if (neg) begin
         delta = -delta;
      end
      sum = {base[23], base} + delta;
      if (sum[24] != sum[23]) begin
         return sum[24] ? POS_MIN : POS_MAX;
      end
      return sum[23:0];
   endfunction

   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;
   assign csr_ready = 1'b1;

   assign is_draw     = req_payload.symbol inside {SYM_A, SYM_B};
   assign heading_eff = req_payload.path_begin ? HEADING_RESET : heading_ff;
   assign cos_addr    = sine_addr(heading_eff + QUARTER_TURN);
   assign sin_addr    = sine_addr(heading_eff);

   always_comb begin
      case (req_payload.symbol)
         SYM_PLUS:  heading_in = heading_eff - turn_angle_ff;
         SYM_MINUS: heading_in = heading_eff + turn_angle_ff;
         default:   heading_in = heading_eff;
      endcase
   end

   tpsg_sine_rom u_sine_rom (
      .clock     (clock),
      .rd_en     (pipe_en),
      .rd_addr_a (cos_addr.idx),
      .rd_addr_b (sin_addr.idx),
      .rd_data_a (cos_mag),
      .rd_data_b (sin_mag)
   );

   assign dmag_x_in = scale_step(step_length_ff, cos_mag);
   assign dmag_y_in = scale_step(step_length_ff, sin_mag);

   assign base_x = s2_ff.path_begin ? start_x_ff : pen_x_ff;
   assign base_y = s2_ff.path_begin ? start_y_ff : pen_y_ff;
   assign next_x = sat_add(base_x, s2_dmag_x_ff, s2_neg_x_ff);
   assign next_y = sat_add(base_y, s2_dmag_y_ff, s2_neg_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= STEP_LENGTH_RESET;
         turn_angle_ff  <= TURN_ANGLE_RESET;
         start_x_ff     <= START_X_RESET;
         start_y_ff     <= START_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_LENGTH: step_length_ff <= csr_wdata[15:0];
            CSR_TURN_ANGLE:  turn_angle_ff  <= csr_wdata[15:0];
            CSR_START_X:     start_x_ff     <= csr_wdata;
            CSR_START_Y:     start_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff   <= HEADING_RESET;
         pen_x_ff     <= START_X_RESET;
         pen_y_ff     <= START_Y_RESET;
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         if (accept) begin
            heading_ff <= heading_in;
         end
         s1_ff.valid      <= accept;
         s1_ff.draw       <= is_draw;
         s1_ff.path_begin <= req_payload.path_begin;
         s2_ff            <= s1_ff;
         rsp_valid_ff     <= s2_ff.valid && s2_ff.draw;
         // A path start with a non-draw symbol still moves the pen home.
         if (s2_ff.valid && s2_ff.draw) begin
            pen_x_ff <= next_x;
            pen_y_ff <= next_y;
         end else if (s2_ff.valid && s2_ff.path_begin) begin
            pen_x_ff <= start_x_ff;
            pen_y_ff <= start_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_neg_x_ff           <= cos_addr.neg;
         s1_neg_y_ff           <= sin_addr.neg;
         s2_neg_x_ff           <= s1_neg_x_ff;
         s2_neg_y_ff           <= s1_neg_y_ff;
         s2_dmag_x_ff          <= dmag_x_in;
         s2_dmag_y_ff          <= dmag_y_in;
         rsp_payload_ff.from_x <= base_x;
         rsp_payload_ff.from_y <= base_y;
         rsp_payload_ff.to_x   <= next_x;
         rsp_payload_ff.to_y   <= next_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/tpsg_checker.sv =====
// Port-level checker for the turtle path segment generator and its bind.
`include "assert_macros.svh"

module tpsg_checker
   import tpsg_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload,
   input logic            csr_ready
);

   // A result held back by the sink stays put.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // Back pressure on the result side reaches the command side at once.
   `ASSERT_CLK(a_stall_chain, rsp_valid && rsp_stall |-> req_stall)

   // Without a waiting stalled result the block always takes a symbol.
   `ASSERT_CLK(a_no_idle_stall, !(rsp_valid && rsp_stall) |-> !req_stall)

   // No result comes out of reset and the register port never waits.
   `ASSERT_CLK_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && csr_ready)

endmodule

bind turtle_path_segment_generator tpsg_checker u_tpsg_checker (.*);
